[hdl/bpe_pkg.sv]
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types, token codes and the byte class function of the BPE encoder.
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int TokW = 13;
  localparam int KeyW = 2 * TokW;

  localparam logic [TokW-1:0] BEGIN_TOKEN = TokW'(256);
  localparam logic [TokW-1:0] END_TOKEN   = TokW'(257);
  localparam int              FIRST_MERGE = 258;

  typedef enum logic [1:0] {
    MODE_RULE = 2'd0,
    MODE_BYTE = 2'd1,
    MODE_END  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CLS_LETTER = 2'd0,
    CLS_DIGIT  = 2'd1,
    CLS_SPACE  = 2'd2,
    CLS_OTHER  = 2'd3
  } class_e;

  // Character class of a raw byte.
  function automatic class_e class_of(input logic [7:0] b);
    class_e c;
    if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
      c = CLS_LETTER;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      c = CLS_DIGIT;
    end else if ((b >= 8'h09 && b <= 8'h0D) || b == 8'h20) begin
      c = CLS_SPACE;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage

[hdl/bpe_ram.sv]
// ----------------------------------------------------------------------------
// bpe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bpe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/bpe_token_encoder_unit.sv]
// ----------------------------------------------------------------------------
// bpe_token_encoder_unit
// Byte-pair-encoding tokenizer with a loadable merge table.
// ----------------------------------------------------------------------------
// Usage: a transaction is accepted when start_i is high and busy_o is low.
// mode_i selects a rule load (left_token_i, right_token_i), a text byte
// (text_byte_i) or end of text. Results appear on token_o, last_o and error_o
// for one cycle each, marked by valid_o; the receiver cannot stall them.
// A rejected rule gives one error result. A text byte that does not close
// a piece is appended to it. Closing a piece runs merge rounds: each round
// scans the merge table once through its single read port, from the newest
// rule down, and then merges the best pair. A piece of n tokens takes at
// most n-1 merging rounds plus one idle round, then emits each surviving
// token in turn. The table scan is what sets the rate.
// Reset clears the rule count, the piece and the begin/end settings; the
// table itself needs no clearing since only loaded rules are read.
// ----------------------------------------------------------------------------
module bpe_token_encoder_unit
  import bpe_pkg::*;
#(
  parameter int MAX_MERGES = 4096,
  parameter int MAX_PIECE  = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic            cfg_data_i,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [1:0]      mode_i,
  input  logic [TokW-1:0] left_token_i,
  input  logic [TokW-1:0] right_token_i,
  input  logic [7:0]      text_byte_i,
  output logic            valid_o,
  output logic [TokW-1:0] token_o,
  output logic            last_o,
  output logic            error_o
);

  localparam int AW = (MAX_MERGES > 1) ? $clog2(MAX_MERGES) : 1;
  localparam int RW = $clog2(MAX_MERGES + 1);
  localparam int CW = (RW > 4) ? RW + 10 : 15;
  localparam int IW = $clog2(MAX_PIECE);
  localparam int PW = $clog2(MAX_PIECE + 1);

  localparam logic CFG_BEGIN = 1'b0;
  localparam logic CFG_END   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_SCAN,
    ST_MERGE,
    ST_EMIT,
    ST_EOS
  } state_e;

  state_e          state_q, state_d;
  logic            add_begin_q, add_end_q;
  logic [RW-1:0]   rule_count_q, rule_count_d;
  logic [TokW-1:0] tok_q [MAX_PIECE];
  logic [TokW-1:0] tok_d [MAX_PIECE];
  logic [PW-1:0]   len_q, len_d;
  class_e          cls_q, cls_d;
  logic            started_q, started_d;
  logic            at_end_q, at_end_d;
  logic [7:0]      byte_q, byte_d;
  logic [AW-1:0]   scan_addr_q, scan_addr_d;
  logic            issuing_q, issuing_d;
  logic            rd_vld_q, rd_vld_d;
  logic [AW-1:0]   rd_rank_q, rd_rank_d;
  logic [MAX_PIECE-1:0] found_q, found_d;
  logic            best_vld_q, best_vld_d;
  logic [AW-1:0]   best_q, best_d;
  logic [IW-1:0]   at_q, at_d;
  logic            valid_q, valid_d;
  logic [TokW-1:0] token_q, token_d;
  logic            last_q, last_d;
  logic            error_q, error_d;

  logic            ram_we;
  logic [KeyW-1:0] ram_rdata;
  logic [MAX_PIECE-1:0] match;
  logic [IW-1:0]   match_at;
  logic [CW-1:0]   limit;
  logic [CW-1:0]   merged;
  logic            reject;
  class_e          in_cls;
  mode_e           mode;

  assign mode   = mode_e'(mode_i);
  assign in_cls = class_of(text_byte_i);
  assign limit  = CW'(FIRST_MERGE) + CW'(rule_count_q);
  assign merged = CW'(FIRST_MERGE) + CW'(best_q);
  assign reject = (rule_count_q >= RW'(MAX_MERGES)) ||
                  (CW'(left_token_i) >= limit) || (CW'(right_token_i) >= limit);
  assign ram_we = (state_q == ST_IDLE) && start_i && (mode == MODE_RULE) && !reject;

  // Merge table: one entry per rule, key is {left, right}.
  bpe_ram #(
    .Width (KeyW),
    .Depth (MAX_MERGES)
  ) u_rules (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rule_count_q[AW-1:0]),
    .wdata_i ({left_token_i, right_token_i}),
    .raddr_i (scan_addr_q),
    .rdata_o (ram_rdata)
  );

  // Compare the scanned rule against every adjacent pair not yet ranked.
  always_comb begin
    match    = '0;
    match_at = '0;
    for (int i = 0; i < MAX_PIECE - 1; i++) begin
      match[i] = (PW'(i + 1) < len_q) && !found_q[i] &&
                 ({tok_q[i], tok_q[i+1]} == ram_rdata);
    end
    for (int i = MAX_PIECE - 2; i >= 0; i--) begin
      if (match[i]) begin
        match_at = IW'(i);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    rule_count_d = rule_count_q;
    tok_d        = tok_q;
    len_d        = len_q;
    cls_d        = cls_q;
    started_d    = started_q;
    at_end_d     = at_end_q;
    byte_d       = byte_q;
    scan_addr_d  = scan_addr_q;
    issuing_d    = 1'b0;
    rd_vld_d     = 1'b0;
    rd_rank_d    = scan_addr_q;
    found_d      = found_q;
    best_vld_d   = best_vld_q;
    best_d       = best_q;
    at_d         = at_q;
    valid_d      = 1'b0;
    token_d      = token_q;
    last_d       = 1'b0;
    error_d      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (mode)
            MODE_RULE: begin
              if (reject) begin
                valid_d = 1'b1;
                token_d = '0;
                last_d  = 1'b1;
                error_d = 1'b1;
              end else begin
                rule_count_d = rule_count_q + RW'(1);
              end
            end
            MODE_BYTE: begin
              started_d = 1'b1;
              if (!started_q && add_begin_q) begin
                valid_d = 1'b1;
                token_d = BEGIN_TOKEN;
                last_d  = 1'b1;
              end
              if (len_q != '0 && (in_cls != cls_q || len_q >= PW'(MAX_PIECE))) begin
                byte_d   = text_byte_i;
                cls_d    = in_cls;
                at_end_d = 1'b0;
                state_d  = ST_ROUND;
              end else begin
                cls_d             = in_cls;
                tok_d[len_q[IW-1:0]] = TokW'(text_byte_i);
                len_d             = len_q + PW'(1);
              end
            end
            MODE_END: begin
              started_d = 1'b0;
              at_end_d  = 1'b1;
              if (!started_q && add_begin_q) begin
                valid_d = 1'b1;
                token_d = BEGIN_TOKEN;
                last_d  = (len_q == '0) && !add_end_q;
              end
              if (len_q != '0) begin
                state_d = ST_ROUND;
              end else if (add_end_q) begin
                state_d = ST_EOS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROUND: begin
        found_d    = '0;
        best_vld_d = 1'b0;
        if (len_q < PW'(2) || rule_count_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          scan_addr_d = AW'(rule_count_q - RW'(1));
          issuing_d   = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Read the table from the newest rule down; data returns in the next cycle.
        if (issuing_q) begin
          rd_vld_d  = 1'b1;
          rd_rank_d = scan_addr_q;
          if (scan_addr_q != '0) begin
            scan_addr_d = scan_addr_q - AW'(1);
            issuing_d   = 1'b1;
          end
        end
        if (rd_vld_q && match != '0) begin
          found_d    = found_q | match;
          best_vld_d = 1'b1;
          best_d     = rd_rank_q;
          at_d       = match_at;
        end
        if (!issuing_q && !rd_vld_q) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (!best_vld_q) begin
          state_d = ST_EMIT;
        end else begin
          for (int j = 0; j < MAX_PIECE; j++) begin
            if (IW'(j) == at_q) begin
              tok_d[j] = merged[TokW-1:0];
            end else if (IW'(j) > at_q && j < MAX_PIECE - 1) begin
              tok_d[j] = tok_q[j+1];
            end
          end
          len_d   = len_q - PW'(1);
          state_d = ST_ROUND;
        end
      end
      ST_EMIT: begin
        valid_d = 1'b1;
        token_d = tok_q[0];
        last_d  = (len_q == PW'(1)) && !(at_end_q && add_end_q);
        for (int j = 0; j < MAX_PIECE - 1; j++) begin
          tok_d[j] = tok_q[j+1];
        end
        len_d = len_q - PW'(1);
        if (len_q == PW'(1)) begin
          if (at_end_q) begin
            state_d = add_end_q ? ST_EOS : ST_IDLE;
          end else begin
            tok_d[0] = TokW'(byte_q);
            len_d    = PW'(1);
            state_d  = ST_IDLE;
          end
        end
      end
      ST_EOS: begin
        valid_d = 1'b1;
        token_d = END_TOKEN;
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, control and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      add_begin_q  <= 1'b0;
      add_end_q    <= 1'b0;
      rule_count_q <= '0;
      len_q        <= '0;
      cls_q        <= CLS_LETTER;
      started_q    <= 1'b0;
      at_end_q     <= 1'b0;
      issuing_q    <= 1'b0;
      rd_vld_q     <= 1'b0;
      found_q      <= '0;
      best_vld_q   <= 1'b0;
      valid_q      <= 1'b0;
      last_q       <= 1'b0;
      error_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      rule_count_q <= rule_count_d;
      len_q        <= len_d;
      cls_q        <= cls_d;
      started_q    <= started_d;
      at_end_q     <= at_end_d;
      issuing_q    <= issuing_d;
      rd_vld_q     <= rd_vld_d;
      found_q      <= found_d;
      best_vld_q   <= best_vld_d;
      valid_q      <= valid_d;
      last_q       <= last_d;
      error_q      <= error_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BEGIN: add_begin_q <= cfg_data_i;
          CFG_END:   add_end_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    tok_q       <= tok_d;
    byte_q      <= byte_d;
    scan_addr_q <= scan_addr_d;
    rd_rank_q   <= rd_rank_d;
    best_q      <= best_d;
    at_q        <= at_d;
    token_q     <= token_d;
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign token_o = token_q;
  assign last_o  = last_q;
  assign error_o = error_q;

  // The rule count never passes the table size.
  a_rule_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rule_count_q <= RW'(MAX_MERGES))
    else $error("rule count beyond table size");

  // The piece never holds more than its maximum.
  a_piece_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= PW'(MAX_PIECE))
    else $error("piece length beyond maximum");

  // An error result is always the final one of its transaction.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && error_o) |-> last_o)
    else $error("error result not marked last");

  // A merge step always shortens the piece by one token.
  a_merge_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE && best_vld_q) |=> (len_q == $past(len_q) - PW'(1)))
    else $error("merge did not shorten piece");

endmodule

[tb/sv/tb_bpe_token_encoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bpe_token_encoder_unit
// Self-checking testbench of the BPE token encoder. A clocked driver sends
// rule loads, text bytes and end-of-text transactions from a queue with
// random gaps. An in-bench predictor of the merge table and piece encoder
// builds the expected tokens, and a clocked monitor compares each result.
// ----------------------------------------------------------------------------
module tb_bpe_token_encoder_unit;
  import bpe_pkg::*;

  localparam int TableDepth = 4096;
  localparam int PieceDepth = 32;

  typedef struct {
    mode_e            mode;
    logic [TokW-1:0]  left;
    logic [TokW-1:0]  right;
    logic [7:0]       text;
  } txn_t;

  typedef struct {
    logic [TokW-1:0] token;
    logic            last;
    logic            error;
  } tok_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_idx_i = 1'b0;
  logic            cfg_data_i = 1'b0;
  logic            start_i = 1'b0;
  logic            busy_o;
  logic [1:0]      mode_i = '0;
  logic [TokW-1:0] left_token_i = '0;
  logic [TokW-1:0] right_token_i = '0;
  logic [7:0]      text_byte_i = '0;
  logic            valid_o;
  logic [TokW-1:0] token_o;
  logic            last_o;
  logic            error_o;

  bpe_token_encoder_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_o,
    .mode_i, .left_token_i, .right_token_i, .text_byte_i,
    .valid_o, .token_o, .last_o, .error_o
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: settings, merge table and the piece being gathered.
  bit              want_begin, want_end;
  logic [KeyW-1:0] rule_keys[TableDepth];
  int              rules_loaded;
  logic [TokW-1:0] piece_tok[PieceDepth];
  int              piece_next[PieceDepth];
  bit              piece_live[PieceDepth];
  int              piece_len;
  class_e          piece_kind;
  bit              in_text;

  tok_result_t     expected_tokens[$];
  txn_t            pending_txns[$];
  int              fail_cnt;
  int              gap_left;
  bit              no_gaps;
  int              gen_rules;

  function automatic class_e byte_kind(logic [7:0] b);
    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) return CLS_LETTER;
    if (b >= "0" && b <= "9") return CLS_DIGIT;
    if ((b >= 8'd9 && b <= 8'd13) || b == 8'd32) return CLS_SPACE;
    return CLS_OTHER;
  endfunction

  // Newest rule for the pair wins; -1 when no rule matches.
  function automatic int pair_rank(logic [TokW-1:0] a, logic [TokW-1:0] b);
    for (int r = rules_loaded - 1; r >= 0; r--) begin
      if (rule_keys[r] == {a, b}) return r;
    end
    return -1;
  endfunction

  function automatic void push_token(logic [TokW-1:0] t, logic err);
    tok_result_t e;
    e.token = t;
    e.last  = 1'b0;
    e.error = err;
    expected_tokens.insert(expected_tokens.size(), e);
  endfunction

  // Merge the lowest-ranked adjacent pair until none applies, then emit.
  function automatic void settle_piece();
    int best, at, cur, nx, r;
    for (int i = 0; i < piece_len; i++) begin
      piece_live[i] = 1'b1;
      piece_next[i] = i + 1;
    end
    while (piece_len > 0) begin
      best = -1;
      at = 0;
      cur = 0;
      while (piece_next[cur] < piece_len) begin
        nx = piece_next[cur];
        r = pair_rank(piece_tok[cur], piece_tok[nx]);
        if (r >= 0 && (best < 0 || r < best)) begin
          best = r;
          at = cur;
        end
        cur = nx;
      end
      if (best < 0) break;
      nx = piece_next[at];
      piece_tok[at] = TokW'(FIRST_MERGE + best);
      piece_live[nx] = 1'b0;
      piece_next[at] = piece_next[nx];
    end
    for (int i = 0; i < piece_len; i++) begin
      if (piece_live[i]) push_token(piece_tok[i], 1'b0);
    end
    piece_len = 0;
  endfunction

  // Expected results of one accepted transaction.
  function automatic void encode_step(logic [1:0] m, logic [TokW-1:0] l,
                                      logic [TokW-1:0] r, logic [7:0] b);
    int before_cnt;
    class_e k;
    before_cnt = expected_tokens.size();
    case (mode_e'(m))
      MODE_RULE: begin
        if (rules_loaded >= TableDepth || l >= FIRST_MERGE + rules_loaded ||
            r >= FIRST_MERGE + rules_loaded) begin
          push_token('0, 1'b1);
        end else begin
          rule_keys[rules_loaded] = {l, r};
          rules_loaded++;
        end
      end
      MODE_BYTE: begin
        k = byte_kind(b);
        if (!in_text) begin
          in_text = 1'b1;
          if (want_begin) push_token(BEGIN_TOKEN, 1'b0);
        end
        if (piece_len > 0 && (k != piece_kind || piece_len >= PieceDepth)) begin
          settle_piece();
        end
        piece_kind = k;
        piece_tok[piece_len] = TokW'(b);
        piece_len++;
      end
      MODE_END: begin
        if (!in_text && want_begin) push_token(BEGIN_TOKEN, 1'b0);
        settle_piece();
        if (want_end) push_token(END_TOKEN, 1'b0);
        in_text = 1'b0;
      end
      default: ;
    endcase
    if (expected_tokens.size() > before_cnt) begin
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  // Driver: predicts on acceptance, then presents the next transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    txn_t t;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      gap_left = 0;
    end else begin
      if (start_i && !busy_o) begin
        encode_step(mode_i, left_token_i, right_token_i, text_byte_i);
        gap_left = no_gaps ? 0 : $urandom_range(0, 5);
      end
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_txns.size() > 0) begin
          t = pending_txns.pop_front();
          start_i       <= 1'b1;
          mode_i        <= t.mode;
          left_token_i  <= t.left;
          right_token_i <= t.right;
          text_byte_i   <= t.text;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    tok_result_t e;
    if (rst_ni && valid_o) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected result token=%0d last=%0b error=%0b",
               token_o, last_o, error_o);
        fail_cnt++;
      end else begin
        e = expected_tokens.pop_front();
        if (token_o !== e.token) begin
          $error("token: expected %0d, got %0d", e.token, token_o);
          fail_cnt++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, last_o);
          fail_cnt++;
        end
        if (error_o !== e.error) begin
          $error("error: expected %0b, got %0b", e.error, error_o);
          fail_cnt++;
        end
      end
    end
  end

  task automatic add_txn(mode_e m, int l, int r, int b);
    txn_t t;
    t.mode  = m;
    t.left  = TokW'(l);
    t.right = TokW'(r);
    t.text  = 8'(b);
    pending_txns.insert(pending_txns.size(), t);
  endtask

  // Rule that the block must take; counts toward the generated table size.
  task automatic add_rule(int l, int r);
    add_txn(MODE_RULE, l, r, $urandom_range(0, 255));
    gen_rules++;
  endtask

  task automatic add_byte(int b);
    add_txn(MODE_BYTE, $urandom_range(0, 8191), $urandom_range(0, 8191), b);
  endtask

  task automatic add_end();
    add_txn(MODE_END, $urandom_range(0, 8191), $urandom_range(0, 8191),
            $urandom_range(0, 255));
  endtask

  // Wait until the block has drained and stays quiet.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_txns.size() > 0 || start_i || expected_tokens.size() > 0 ||
           busy_o);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_config(bit b, bit e);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= 1'b0;
    cfg_data_i <= b;
    @(posedge clk_i);
    cfg_idx_i  <= 1'b1;
    cfg_data_i <= e;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    want_begin = b;
    want_end   = e;
  endtask

  // Byte from a small alphabet so that loaded rules actually fire.
  function automatic int text_pick();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0, 1, 2, 3: return "a";
      4, 5, 6:    return "b";
      7:          return "c";
      8, 9:       return "0";
      10:         return "1";
      11:         return " ";
      12:         return 10;
      13:         return ".";
      default:    return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int operand_pick();
    if (gen_rules > 0 && $urandom_range(0, 2) == 0) begin
      return FIRST_MERGE + $urandom_range(0, gen_rules - 1);
    end
    return text_pick();
  endfunction

  // Stimulus sequence.
  initial begin
    int len;
    fail_cnt = 0;
    no_gaps = 1'b0;
    gen_rules = 0;
    rules_loaded = 0;
    piece_len = 0;
    piece_kind = CLS_LETTER;
    in_text = 1'b0;
    want_begin = 1'b0;
    want_end = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: begin and end framing, rule checks, extremes, full piece.
    set_config(1'b1, 1'b1);
    add_end();
    add_rule("a", "b");
    add_rule(FIRST_MERGE, "c");
    add_rule("a", "b");
    add_txn(MODE_RULE, 8191, 8191, 0);
    add_txn(MODE_RULE, 0, FIRST_MERGE + 3, 255);
    add_rule(FIRST_MERGE + 2, 0);
    add_txn(MODE_NONE, 8191, 8191, 255);
    add_byte("a");
    add_byte("b");
    add_byte("c");
    add_byte(0);
    add_byte(255);
    add_byte("1");
    add_byte("2");
    add_byte(" ");
    add_end();
    for (int i = 0; i < 33; i++) add_byte("a");
    add_end();
    wait_idle();

    // Random part over all four settings of the framing tokens.
    for (int ph = 0; ph < 4; ph++) begin
      set_config(ph[0], ph[1]);
      no_gaps = (ph == 2);
      for (int n = 0; n < 6; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: add_rule(operand_pick(), operand_pick());
          3:       add_txn(MODE_RULE, $urandom_range(4200, 8191),
                           $urandom_range(0, 8191), $urandom_range(0, 255));
          4:       add_txn(MODE_NONE, $urandom_range(0, 8191),
                           $urandom_range(0, 8191), $urandom_range(0, 255));
          default: begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(0, 8);
            for (int i = 0; i < len; i++) add_byte(text_pick());
            if ($urandom_range(0, 4) != 0) add_end();
          end
        endcase
      end
      add_end();
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
